FILE: rtl/pfnt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfnt_pkg
// Types, sequencer states, product schedule and helpers for the fan
// triangulation normal/tangent block.
// ----------------------------------------------------------------------------
package pfnt_pkg;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [32:0] diff_t;
  typedef logic signed [63:0] prod_t;
  typedef logic        [63:0] mag_t;
  typedef logic signed [15:0] q14_t;

  localparam int UNIT_SHIFT = 15;
  localparam int QUOT_W     = 15;
  localparam int NUM_W      = 47;
  localparam int LEN_W      = 32;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EDGE_N, ST_EDGE_T, ST_MUL, ST_ACC, ST_NZ_INIT, ST_NZ_SHIFT,
    ST_SQ_MUL, ST_SQ_ACC, ST_ROOT_GO, ST_ROOT_WAIT, ST_DIV_GO, ST_DIV_WAIT,
    ST_NEXT, ST_OUT
  } state_t;

  typedef enum logic {
    CFG_NORMAL_EN  = 1'b0,
    CFG_TANGENT_EN = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [3:0] ia;
    logic [3:0] ib;
    logic [1:0] dest;
    logic       sub;
  } mstep_t;

  typedef struct packed {
    logic tdeg;
    logic ndeg;
    q14_t tz;
    q14_t ty;
    q14_t tx;
    q14_t nz;
    q14_t ny;
    q14_t nx;
  } result_t;

  // product schedule: normal uses operands 0..5, tangent adds uv at 6..9
  function automatic mstep_t mul_step(logic tan, logic [2:0] j);
    mstep_t s;
    unique case ({tan, j})
      4'b0000: s = '{4'd1, 4'd5, 2'd0, 1'b0};
      4'b0001: s = '{4'd2, 4'd4, 2'd0, 1'b1};
      4'b0010: s = '{4'd2, 4'd3, 2'd1, 1'b0};
      4'b0011: s = '{4'd0, 4'd5, 2'd1, 1'b1};
      4'b0100: s = '{4'd0, 4'd4, 2'd2, 1'b0};
      4'b0101: s = '{4'd1, 4'd3, 2'd2, 1'b1};
      4'b1000: s = '{4'd6, 4'd9, 2'd3, 1'b0};
      4'b1001: s = '{4'd8, 4'd7, 2'd3, 1'b1};
      4'b1010: s = '{4'd0, 4'd9, 2'd0, 1'b0};
      4'b1011: s = '{4'd3, 4'd7, 2'd0, 1'b1};
      4'b1100: s = '{4'd1, 4'd9, 2'd1, 1'b0};
      4'b1101: s = '{4'd4, 4'd7, 2'd1, 1'b1};
      4'b1110: s = '{4'd2, 4'd9, 2'd2, 1'b0};
      4'b1111: s = '{4'd5, 4'd7, 2'd2, 1'b1};
      default: s = '{4'd0, 4'd0, 2'd0, 1'b0};
    endcase
    return s;
  endfunction

  function automatic diff_t sub33(coord_t a, coord_t b);
    return diff_t'({a[31], a}) - diff_t'({b[31], b});
  endfunction

  function automatic logic [32:0] mag33(diff_t d);
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  function automatic logic [1:0] grp_shift(logic [32:0] orm);
    return (orm[32] || orm[31]) ? 2'd1 : 2'd0;
  endfunction

  function automatic coord_t scale(diff_t d, logic [1:0] sh);
    logic [32:0] mg;
    mg = mag33(d) >> sh;
    return d[32] ? -coord_t'(mg[31:0]) : coord_t'(mg[31:0]);
  endfunction

endpackage

FILE: rtl/pfnt_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfnt_mul
// Shared signed 32x32 multiplier with registered product.
// ----------------------------------------------------------------------------
module pfnt_mul (
  input  logic            clk,
  input  pfnt_pkg::coord_t a,
  input  pfnt_pkg::coord_t b,
  output pfnt_pkg::prod_t  prod
);
  import pfnt_pkg::*;

  always_ff @(posedge clk) begin
    prod <= prod_t'(a) * prod_t'(b);
  end
endmodule

FILE: rtl/pfnt_root.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfnt_root
// Integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module pfnt_root (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  pfnt_pkg::mag_t            x,
  output logic                      done,
  output logic [pfnt_pkg::LEN_W-1:0] root
);
  import pfnt_pkg::*;

  mag_t xr, r, bitv;
  logic busy;
  logic [63:0] trial;

  assign trial = r + bitv;
  assign root  = r[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitv == 64'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xr   <= x;
      r    <= '0;
      bitv <= 64'd1 << 62;
    end else if (busy) begin
      if (xr >= trial) begin
        xr <= xr - trial;
        r  <= (r >> 1) + bitv;
      end else begin
        r <= r >> 1;
      end
      bitv <= bitv >> 2;
    end
  end
endmodule

FILE: rtl/pfnt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfnt_div
// Restoring divider, one quotient bit per cycle, 15-bit quotient.
// ----------------------------------------------------------------------------
module pfnt_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pfnt_pkg::NUM_W-1:0]  num,
  input  logic [pfnt_pkg::LEN_W-1:0]  den,
  output logic                        done,
  output logic [pfnt_pkg::QUOT_W-1:0] quot
);
  import pfnt_pkg::*;

  logic [NUM_W-1:0] rem, dsh;
  logic [3:0] cnt;
  logic busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 4'(QUOT_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsh  <= NUM_W'(den) << (QUOT_W - 1);
      quot <= '0;
      cnt  <= '0;
    end else if (busy) begin
      if (rem >= dsh) begin
        rem  <= rem - dsh;
        quot <= {quot[QUOT_W-2:0], 1'b1};
      end else begin
        quot <= {quot[QUOT_W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
      cnt <= cnt + 4'd1;
    end
  end
endmodule

FILE: rtl/pfnt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfnt_core
// Vertex state and sequencer: edges, products, normalize, square root, divide.
// ----------------------------------------------------------------------------
module pfnt_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  pfnt_pkg::coord_t  in_pos [3],
  input  pfnt_pkg::coord_t  in_tex [2],
  input  logic              in_first,
  input  logic              normal_en,
  input  logic              tangent_en,
  input  logic              out_free,
  output logic              idle,
  output logic              res_load,
  output pfnt_pkg::result_t res
);
  import pfnt_pkg::*;

  state_t state, state_next;
  coord_t fpos [3], ppos [3], cpos [3];
  coord_t ftex [2], ptex [2], ctex [2];
  logic [1:0] vcnt;
  coord_t opr [10];
  prod_t  v [4];
  mag_t   m [3];
  logic   neg [3];
  logic   flip, tan;
  logic [2:0] j;
  logic [1:0] k;
  mag_t   sum;
  logic [LEN_W-1:0] len;
  q14_t   nres [3], tres [3];
  logic   ndeg, tdeg;

  mstep_t ms;
  coord_t ma, mb;
  prod_t  prod;
  logic   root_done, div_done;
  logic [LEN_W-1:0] root;
  logic [QUOT_W-1:0] quot;
  diff_t  d [6];
  diff_t  du [4];
  logic [32:0] orm, oru;
  logic [1:0] shd, shu;
  mag_t   orv;
  logic   v_zero;
  logic   det_zero;
  q14_t   qs;

  assign ms = mul_step(tan, j);
  assign idle = state == ST_IDLE;
  assign res_load = state == ST_OUT && out_free;
  assign orv = m[0] | m[1] | m[2];
  assign v_zero = v[0] == '0 && v[1] == '0 && v[2] == '0;
  assign det_zero = v[3] == '0;
  assign qs = (neg[k] ^ flip) ? -q14_t'(quot) : q14_t'(quot);

  always_comb begin
    orm = '0;
    oru = '0;
    for (int i = 0; i < 3; i++) begin
      if (state == ST_EDGE_N) begin
        d[i]     = sub33(cpos[i], ppos[i]);
        d[3 + i] = sub33(fpos[i], ppos[i]);
      end else begin
        d[i]     = sub33(cpos[i], fpos[i]);
        d[3 + i] = sub33(ppos[i], fpos[i]);
      end
    end
    du[0] = sub33(ctex[0], ftex[0]);
    du[1] = sub33(ctex[1], ftex[1]);
    du[2] = sub33(ptex[0], ftex[0]);
    du[3] = sub33(ptex[1], ftex[1]);
    for (int i = 0; i < 6; i++) orm = orm | mag33(d[i]);
    for (int i = 0; i < 4; i++) oru = oru | mag33(du[i]);
    shd = grp_shift(orm);
    shu = grp_shift(oru);
  end

  always_comb begin
    if (state == ST_SQ_MUL) begin
      ma = coord_t'(m[k][31:0]);
      mb = coord_t'(m[k][31:0]);
    end else begin
      ma = opr[ms.ia];
      mb = opr[ms.ib];
    end
  end

  pfnt_mul u_mul (.clk(clk), .a(ma), .b(mb), .prod(prod));

  pfnt_root u_root (
    .clk(clk), .rst(rst), .start(state == ST_ROOT_GO), .x(sum),
    .done(root_done), .root(root)
  );

  pfnt_div u_div (
    .clk(clk), .rst(rst), .start(state == ST_DIV_GO),
    .num(NUM_W'({m[k][29:0], {UNIT_SHIFT{1'b0}}}) + NUM_W'(len)),
    .den({len[LEN_W-2:0], 1'b0}), .done(div_done), .quot(quot)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && !in_first && vcnt == 2'd2) begin
          priority if (normal_en)  state_next = ST_EDGE_N;
          else if (tangent_en)     state_next = ST_EDGE_T;
          else                     state_next = ST_OUT;
        end
      end
      ST_EDGE_N, ST_EDGE_T: state_next = ST_MUL;
      ST_MUL:      state_next = ST_ACC;
      ST_ACC:      state_next = (j == (tan ? 3'd7 : 3'd5)) ? ST_NZ_INIT : ST_MUL;
      ST_NZ_INIT:  state_next = (v_zero || (tan && det_zero)) ? ST_NEXT : ST_NZ_SHIFT;
      ST_NZ_SHIFT: begin
        if (!(|orv[63:30]) && orv[29]) state_next = ST_SQ_MUL;
      end
      ST_SQ_MUL:   state_next = ST_SQ_ACC;
      ST_SQ_ACC:   state_next = (k == 2'd2) ? ST_ROOT_GO : ST_SQ_MUL;
      ST_ROOT_GO:  state_next = ST_ROOT_WAIT;
      ST_ROOT_WAIT: if (root_done) state_next = ST_DIV_GO;
      ST_DIV_GO:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_next = (k == 2'd2) ? ST_NEXT : ST_DIV_GO;
      ST_NEXT:     state_next = (!tan && tangent_en) ? ST_EDGE_T : ST_OUT;
      ST_OUT:      if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcnt <= '0;
      for (int i = 0; i < 3; i++) begin
        fpos[i] <= '0;
        ppos[i] <= '0;
      end
      for (int i = 0; i < 2; i++) begin
        ftex[i] <= '0;
        ptex[i] <= '0;
      end
    end else if (state == ST_IDLE && start) begin
      if (in_first || vcnt == 2'd0) begin
        fpos <= in_pos;
        ppos <= in_pos;
        ftex <= in_tex;
        ptex <= in_tex;
        vcnt <= 2'd1;
      end else if (vcnt == 2'd1) begin
        ppos <= in_pos;
        ptex <= in_tex;
        vcnt <= 2'd2;
      end
    end else if (res_load) begin
      ppos <= cpos;
      ptex <= ctex;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cpos <= in_pos;
        ctex <= in_tex;
        ndeg <= 1'b0;
        tdeg <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          nres[i] <= '0;
          tres[i] <= '0;
        end
      end
      ST_EDGE_N, ST_EDGE_T: begin
        for (int i = 0; i < 6; i++) opr[i] <= scale(d[i], shd);
        for (int i = 0; i < 4; i++) opr[6 + i] <= scale(du[i], shu);
        tan  <= state == ST_EDGE_T;
        flip <= 1'b0;
        j    <= '0;
      end
      ST_ACC: begin
        v[ms.dest] <= ms.sub ? v[ms.dest] - prod : prod;
        j <= j + 3'd1;
      end
      ST_NZ_INIT: begin
        for (int i = 0; i < 3; i++) begin
          m[i]   <= v[i][63] ? mag_t'(-v[i]) : mag_t'(v[i]);
          neg[i] <= v[i][63];
        end
        flip <= tan && v[3][63];
        k    <= '0;
        if (v_zero || (tan && det_zero)) begin
          if (tan) tdeg <= 1'b1;
          else     ndeg <= 1'b1;
        end
      end
      ST_NZ_SHIFT: begin
        for (int i = 0; i < 3; i++) begin
          priority if (|orv[63:34])   m[i] <= m[i] >> 4;
          else if (|orv[63:30])       m[i] <= m[i] >> 1;
          else if (!(|orv[63:25]))    m[i] <= m[i] << 4;
          else if (!(|orv[63:29]))    m[i] <= m[i] << 1;
          else                        m[i] <= m[i];
        end
      end
      ST_SQ_ACC: begin
        sum <= (k == 2'd0) ? mag_t'(prod) : sum + mag_t'(prod);
        k   <= (k == 2'd2) ? 2'd0 : k + 2'd1;
      end
      ST_ROOT_WAIT: begin
        if (root_done) len <= root;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (tan) tres[k] <= qs;
          else     nres[k] <= qs;
          k <= k + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign res = '{tdeg: tdeg, ndeg: ndeg,
                 tz: tres[2], ty: tres[1], tx: tres[0],
                 nz: nres[2], ny: nres[1], nx: nres[0]};
endmodule

FILE: rtl/polygon_fan_normal_tangent.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_fan_normal_tangent
// Fan triangulation of polygons with unit face normal and unit tangent.
//
//   channel | dir | width        | content
//   s_*     | in  | 160 + 1 user | one vertex request
//   m_*     | out | 96 + 2 user  | one triangle result
//   cfg_*   | in  | 1 idx, 1 dat | enable register write
//
// First and second vertex of a polygon are only stored and give no result.
// Triangle, per enabled vector: six or eight products on the shared
// multiplier, a 32-step square root and three 15-step divides; a zero
// vector or zero determinant skips the root and the divides.
// Reset is synchronous; one finished result waits in the output register.
// ----------------------------------------------------------------------------
module polygon_fan_normal_tangent (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [159:0] s_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v
  input  logic         s_tuser,   // polygon_start
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,   // normal_x/y/z, tangent_x/y/z
  output logic [1:0]   m_tuser,   // normal_degenerate, tangent_degenerate
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic         cfg_data
);
  import pfnt_pkg::*;

  logic normal_en, tangent_en;
  logic idle, res_load, out_free;
  result_t res;
  coord_t in_pos [3];
  coord_t in_tex [2];

  assign cfg_ready = 1'b1;
  assign s_tready  = idle;
  assign out_free  = !m_tvalid || m_tready;

  assign in_pos[0] = s_tdata[31:0];
  assign in_pos[1] = s_tdata[63:32];
  assign in_pos[2] = s_tdata[95:64];
  assign in_tex[0] = s_tdata[127:96];
  assign in_tex[1] = s_tdata[159:128];

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_en  <= 1'b1;
      tangent_en <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_NORMAL_EN:  normal_en  <= cfg_data;
        CFG_TANGENT_EN: tangent_en <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pfnt_core u_core (
    .clk(clk), .rst(rst), .start(s_tvalid && s_tready),
    .in_pos(in_pos), .in_tex(in_tex), .in_first(s_tuser),
    .normal_en(normal_en), .tangent_en(tangent_en), .out_free(out_free),
    .idle(idle), .res_load(res_load), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst)           m_tvalid <= 1'b0;
    else if (res_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      m_tdata <= {res.tz, res.ty, res.tx, res.nz, res.ny, res.nx};
      m_tuser <= {res.tdeg, res.ndeg};
    end
  end
endmodule

FILE: rtl/pfnt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfnt_checker
// Port-level checks on the fan normal/tangent block.
// ----------------------------------------------------------------------------
module pfnt_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [95:0]  m_tdata,
  input logic [1:0]   m_tuser
);
  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_ndeg_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[47:0] == 48'd0)
    else $error("degenerate normal not zero");

  a_tdeg_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata[95:48] == 48'd0)
    else $error("degenerate tangent not zero");

  a_first_no_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !$rose(m_tvalid))
    else $error("result after first vertex");
endmodule

bind polygon_fan_normal_tangent pfnt_checker u_pfnt_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser)
);

FILE: tb/polygon_fan_normal_tangent_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_fan_normal_tangent_tb
// Sends polygon vertices into the fan triangulation block and checks each
// triangle's unit normal, unit tangent and degenerate flags against a
// predictor kept in this bench. Covers both enable registers in every
// combination, coordinate extremes, degenerate triangles and random stalls.
// ----------------------------------------------------------------------------
module polygon_fan_normal_tangent_tb;
  import pfnt_pkg::*;

  typedef struct {
    logic signed [31:0] px, py, pz, tu, tv;
    logic               start;
  } vertex_t;

  typedef struct packed {
    logic signed [15:0] nx, ny, nz, tx, ty, tz;
    logic               ndeg, tdeg;
  } tri_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [159:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [95:0]  m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_index = 1'b0;
  logic         cfg_data = 1'b0;

  // predictor state
  longint fpos [3];
  longint ftex [2];
  longint ppos [3];
  longint ptex [2];
  int     vcount;
  bit     nrm_en, tan_en;

  tri_t   expected_tris[$];
  int     errors = 0;
  longint cycles = 0;
  bit     calm = 1'b0;

  polygon_fan_normal_tangent u_top (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd3000000) begin
      $display("FAIL polygon_fan_normal_tangent");
      $finish;
    end
  end

  function automatic longint magn(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void group_scale(ref longint v[6], input int n);
    longint mx;
    int sh;
    mx = 0;
    sh = 0;
    for (int i = 0; i < n; i++) if (magn(v[i]) > mx) mx = magn(v[i]);
    while ((mx >>> sh) >= (64'sd1 <<< 31)) sh++;
    for (int i = 0; i < n; i++)
      v[i] = v[i] < 0 ? -(magn(v[i]) >>> sh) : (v[i] >>> sh);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit to_unit(longint v[3], bit flip, output logic signed [15:0] o[3]);
    longint unsigned m[3], mx, sum, len, q;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
      o[i] = '0;
    end
    if (mx == 0) return 1'b0;
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 32768 + len) / (2 * len);
      o[i] = ((v[i] < 0) != flip) ? -q[15:0] : q[15:0];
    end
    return 1'b1;
  endfunction

  function automatic void predict_triangle(vertex_t vx);
    longint p[3], t[2], e[6], uv[6], nv[3], tv[3], det;
    logic signed [15:0] o[3];
    tri_t r;
    p[0] = vx.px; p[1] = vx.py; p[2] = vx.pz;
    t[0] = vx.tu; t[1] = vx.tv;
    if (vx.start || vcount == 0) begin
      fpos = p; ppos = p; ftex = t; ptex = t;
      vcount = 1;
      return;
    end
    if (vcount == 1) begin
      ppos = p; ptex = t;
      vcount = 2;
      return;
    end
    r = '{default: '0};
    if (nrm_en) begin
      for (int i = 0; i < 3; i++) begin
        e[i] = p[i] - ppos[i];
        e[3+i] = fpos[i] - ppos[i];
      end
      group_scale(e, 6);
      nv[0] = e[1]*e[5] - e[2]*e[4];
      nv[1] = e[2]*e[3] - e[0]*e[5];
      nv[2] = e[0]*e[4] - e[1]*e[3];
      r.ndeg = !to_unit(nv, 1'b0, o);
      r.nx = o[0]; r.ny = o[1]; r.nz = o[2];
    end
    if (tan_en) begin
      for (int i = 0; i < 3; i++) begin
        e[i] = p[i] - fpos[i];
        e[3+i] = ppos[i] - fpos[i];
      end
      group_scale(e, 6);
      uv[0] = t[0] - ftex[0];
      uv[1] = t[1] - ftex[1];
      uv[2] = ptex[0] - ftex[0];
      uv[3] = ptex[1] - ftex[1];
      uv[4] = 0; uv[5] = 0;
      group_scale(uv, 4);
      det = uv[0]*uv[3] - uv[2]*uv[1];
      for (int i = 0; i < 3; i++) tv[i] = e[i]*uv[3] - e[3+i]*uv[1];
      if (det == 0) r.tdeg = 1'b1;
      else r.tdeg = !to_unit(tv, det < 0, o);
      if (!r.tdeg) begin
        r.tx = o[0]; r.ty = o[1]; r.tz = o[2];
      end
    end
    expected_tris = {expected_tris, r};
    ppos = p; ptex = t;
  endfunction

  // result checker with random receiver stalls
  int hold_rx = 0;
  always @(posedge clk) begin
    tri_t g, w;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        g.nx = m_tdata[15:0];  g.ny = m_tdata[31:16]; g.nz = m_tdata[47:32];
        g.tx = m_tdata[63:48]; g.ty = m_tdata[79:64]; g.tz = m_tdata[95:80];
        g.ndeg = m_tuser[0];   g.tdeg = m_tuser[1];
        if (expected_tris.size() == 0) begin
          $display("%0t unexpected result nx=%0d ny=%0d nz=%0d", $time, g.nx, g.ny, g.nz);
          errors++;
        end else begin
          w = expected_tris.pop_front();
          if (g != w) begin
            $display("%0t mismatch exp n=(%0d %0d %0d) t=(%0d %0d %0d) deg=%b%b", $time,
                     w.nx, w.ny, w.nz, w.tx, w.ty, w.tz, w.ndeg, w.tdeg);
            $display("%0t          got n=(%0d %0d %0d) t=(%0d %0d %0d) deg=%b%b", $time,
                     g.nx, g.ny, g.nz, g.tx, g.ty, g.tz, g.ndeg, g.tdeg);
            errors++;
          end
        end
      end
      if (hold_rx > 0) begin
        hold_rx--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        hold_rx = $urandom_range(1, 10);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // valid stays high after the request; a gap in the next call or drain drops it
  task automatic send_vertex(vertex_t vx);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {vx.tv, vx.tu, vx.pz, vx.py, vx.px};
    s_tuser  <= vx.start;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_triangle(vx);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_tris.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, bit val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_NORMAL_EN) nrm_en = val;
    else tan_en = val;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 2000) - 1000;
      2: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 50)
                                     : 32'h80000000 + $urandom_range(0, 50);
      default: return ($urandom() >> $urandom_range(0, 30)) ^ ($urandom_range(0, 1) ? '1 : '0);
    endcase
  endfunction

  function automatic vertex_t mk(int px, int py, int pz, int tu, int tv, bit st);
    vertex_t v;
    v.px = px; v.py = py; v.pz = pz; v.tu = tu; v.tv = tv; v.start = st;
    return v;
  endfunction

  task automatic test_directed();
    int mn, mx;
    mn = 32'h80000000;
    mx = 32'h7fffffff;
    send_vertex(mk(0, 0, 0, 0, 0, 1'b0));
    send_vertex(mk(65536, 0, 0, 65536, 0, 1'b0));
    send_vertex(mk(0, 65536, 0, 0, 65536, 1'b0));
    send_vertex(mk(-65536, 0, 0, 65536, -65536, 1'b0));
    send_vertex(mk(mn, mn, mn, mn, mn, 1'b1));
    send_vertex(mk(mx, mx, mx, mx, mx, 1'b0));
    send_vertex(mk(mx, mn, mx, mn, mx, 1'b0));
    send_vertex(mk(mn, mx, mn, mx, mx, 1'b0));
    // collinear points and repeated texcoords
    send_vertex(mk(1, 2, 3, 5, 5, 1'b1));
    send_vertex(mk(2, 4, 6, 5, 5, 1'b0));
    send_vertex(mk(3, 6, 9, 5, 5, 1'b0));
    send_vertex(mk(3, 6, 9, 9, 7, 1'b0));
    // positive determinant
    send_vertex(mk(0, 0, 0, 0, 0, 1'b1));
    send_vertex(mk(100, 0, 0, 0, 100, 1'b0));
    send_vertex(mk(0, 100, 0, 100, 0, 1'b0));
    drain();
  endtask

  task automatic test_random(int count);
    vertex_t v;
    int mode, left;
    left = 0;
    for (int i = 0; i < count; i++) begin
      if (left == 0) begin
        left = $urandom_range(3, 8);
        mode = $urandom_range(0, 3);
        v.start = ($urandom_range(0, 9) != 0);
      end else begin
        v.start = ($urandom_range(0, 40) == 0);
      end
      left--;
      v.px = rand_coord(mode); v.py = rand_coord(mode); v.pz = rand_coord(mode);
      v.tu = rand_coord(mode); v.tv = rand_coord(mode);
      if ($urandom_range(0, 30) == 0) v.tu = ftex[0][31:0];
      send_vertex(v);
    end
  endtask

  task automatic test_config_sweep();
    write_reg(CFG_NORMAL_EN, 1'b0);
    write_reg(CFG_TANGENT_EN, 1'b1);
    test_random(100);
    drain();
    write_reg(CFG_TANGENT_EN, 1'b0);
    test_random(60);
    drain();
    write_reg(CFG_NORMAL_EN, 1'b1);
    test_random(100);
    drain();
    write_reg(CFG_TANGENT_EN, 1'b1);
  endtask

  initial begin
    nrm_en = 1'b1;
    tan_en = 1'b1;
    vcount = 0;
    fpos = '{0, 0, 0}; ppos = '{0, 0, 0};
    ftex = '{0, 0}; ptex = '{0, 0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_random(900);
    drain();
    calm = 1'b1;
    test_random(200);
    drain();
    if (errors == 0) begin
      $display("PASS polygon_fan_normal_tangent");
    end else begin
      $display("FAIL polygon_fan_normal_tangent");
    end
    $finish;
  end

endmodule
